// ===== src/gfx_pkg.sv =====
// Shared constants for the guitar effects sample processor.
package gfx_pkg;

    localparam int REVERB_DEPTH_DEF = 16384;
    localparam int WAH_DEPTH_DEF    = 131072;
    localparam int SAMPLE_BITS_DEF  = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_FX_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_COEFF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERB_DECAY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERB_LENGTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TREM_PERIOD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TREM_OFF_GAIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_WAH_LENGTH    = 3'd7;

    localparam logic [2:0] MODE_BYPASS    = 3'd0;
    localparam logic [2:0] MODE_OVERDRIVE = 3'd1;
    localparam logic [2:0] MODE_DIST      = 3'd2;
    localparam logic [2:0] MODE_REVERB    = 3'd3;
    localparam logic [2:0] MODE_TREMOLO   = 3'd4;
    localparam logic [2:0] MODE_WAH       = 3'd5;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEFF  = 1'b1;

    localparam int TENTH_Q15 = 3277;

endpackage

// ===== src/gfx_div.sv =====
// Restoring divider for the overdrive quotient, one quotient bit per cycle.
module gfx_div import gfx_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [SAMPLE_BITS+15:0] i_num,
    input  logic [SAMPLE_BITS+15:0] i_den,
    output logic                    o_done,
    output logic [SAMPLE_BITS+1:0]  o_quot
);

    localparam int F  = SAMPLE_BITS - 1;
    localparam int QW = SAMPLE_BITS + 2;
    localparam int DW = SAMPLE_BITS + 16;
    localparam int RW = SAMPLE_BITS + 17;
    localparam int CW = $clog2(QW + 1);

    logic [RW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_q;
    logic [QW-1:0] r_sh;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [RW-1:0] rem2;
    logic [RW-1:0] n_rem;
    logic          ge;

    // quotient is below 2^QW, so the top bits of the numerator start below den
    always_comb begin
        rem2  = {r_rem[RW-2:0], r_sh[QW-1]};
        ge    = rem2 >= {1'b0, r_den};
        n_rem = ge ? (rem2 - {1'b0, r_den}) : rem2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= RW'(i_num >> 3);
                r_sh   <= {i_num[2:0], {F{1'b0}}};
                r_den  <= i_den;
                r_q    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= {r_q[QW-2:0], ge};
                r_sh  <= r_sh << 1;
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== src/guitar_effects_sample_processor_core.sv =====
// Flow: one item at a time; the next item is taken once the result is in the output
// register. Overdrive's quotient comes from the divider, one bit per cycle. Coefficient
// writes are taken in the idle state and give no result.
// Reset: synchronous active low; afterwards a pass over all REVERB_DEPTH entries zeroes the
// delay line while input is stalled. Configuration writes are taken at any time.
module guitar_effects_sample_processor_core import gfx_pkg::*; #(
    parameter int REVERB_DEPTH = REVERB_DEPTH_DEF,
    parameter int WAH_DEPTH    = WAH_DEPTH_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_op,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic [16:0]                   i_coeff_index,
    input  logic [15:0]                   i_coeff_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out
);

    localparam int SB = SAMPLE_BITS;
    localparam int F  = SB - 1;
    localparam int PW = SB + 19;
    localparam int NW = SB + 16;
    localparam int QW = SB + 2;
    localparam int RA = $clog2(REVERB_DEPTH);
    localparam int WA = $clog2(WAH_DEPTH);

    localparam logic signed [PW-1:0] SMAXP = PW'((64'd1 << F) - 64'd1);
    localparam logic signed [PW-1:0] SMINP = -SMAXP - PW'(1);
    localparam longint CLIP_LVL = ((longint'(1) << SB) + 5) / 10;
    localparam logic signed [PW-1:0] CLIP_P  = PW'(CLIP_LVL * 4096);
    localparam logic signed [PW-1:0] NCLIP_P = PW'(-(CLIP_LVL * 4096));

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_OD_A  = 5'd2;
    localparam logic [4:0] S_OD_B  = 5'd3;
    localparam logic [4:0] S_OD_C  = 5'd4;
    localparam logic [4:0] S_OD_W  = 5'd5;
    localparam logic [4:0] S_DI_M  = 5'd6;
    localparam logic [4:0] S_DI_R  = 5'd7;
    localparam logic [4:0] S_RV_M  = 5'd8;
    localparam logic [4:0] S_RV_W  = 5'd9;
    localparam logic [4:0] S_TR_M  = 5'd10;
    localparam logic [4:0] S_TR_R  = 5'd11;
    localparam logic [4:0] S_WH_M1 = 5'd12;
    localparam logic [4:0] S_WH_H  = 5'd13;
    localparam logic [4:0] S_WH_M2 = 5'd14;
    localparam logic [4:0] S_WH_B  = 5'd15;
    localparam logic [4:0] S_WH_M3 = 5'd16;
    localparam logic [4:0] S_WH_L  = 5'd17;
    localparam logic [4:0] S_FIN   = 5'd18;

    function automatic logic signed [SB-1:0] sat(input logic signed [PW-1:0] v);
        if (v > SMAXP) begin
            return SMAXP[SB-1:0];
        end else if (v < SMINP) begin
            return SMINP[SB-1:0];
        end
        return v[SB-1:0];
    endfunction

    function automatic logic signed [PW-1:0] ext(input logic signed [SB-1:0] v);
        return $signed({{(PW-SB){v[SB-1]}}, v});
    endfunction

    // arithmetic shift right that rounds toward zero
    function automatic logic signed [PW-1:0] trunc_sh(input logic signed [PW-1:0] p,
                                                      input int sh);
        logic signed [PW-1:0] bias;
        bias = p[PW-1] ? ((PW'(1) << sh) - PW'(1)) : '0;
        return (p + bias) >>> sh;
    endfunction

    // configuration
    logic [2:0]  r_fx_mode;
    logic [15:0] r_drive;
    logic [14:0] r_dist_gain;
    logic [14:0] r_rev_decay;
    logic [14:0] r_rev_len;
    logic [21:0] r_trem_period;
    logic [14:0] r_trem_gain;
    logic [17:0] r_wah_len;

    // state
    logic [4:0]           r_state;
    logic [RA-1:0]        r_clr_cnt;
    logic [RA-1:0]        r_rev_pos;
    logic [21:0]          r_trem_count;
    logic                 r_trem_on;
    logic [WA-1:0]        r_wah_pos;
    logic signed [SB-1:0] r_band;
    logic signed [SB-1:0] r_low;
    logic signed [SB-1:0] r_high;
    logic signed [SB-1:0] r_x;
    logic signed [SB-1:0] r_y;
    logic [NW-1:0]        r_a;
    logic signed [PW-1:0] r_prod;
    logic                 r_out_valid;
    logic signed [SB-1:0] r_out;

    // memories
    logic signed [SB-1:0] rev_mem [REVERB_DEPTH];
    logic [15:0]          wah_mem [WAH_DEPTH];
    logic signed [SB-1:0] r_rev_rd;
    logic [15:0]          r_coef;

    logic                 accept;
    logic                 rev_we;
    logic [RA-1:0]        rev_wa;
    logic signed [SB-1:0] rev_wd;
    logic signed [SB-1:0] rev_v;
    logic                 rev_re;
    logic                 wah_we;
    logic                 wah_re;
    logic [WA-1:0]        wah_wa;
    logic [31:0]          rev_len_eff;
    logic [31:0]          wah_len_eff;
    logic [22:0]          trem_next;
    logic signed [SB:0]   mul_a;
    logic signed [17:0]   mul_b;
    logic signed [PW-1:0] ma_e;
    logic signed [PW-1:0] mb_e;
    logic signed [SB:0]   x_mag;
    logic                 div_start;
    logic                 div_done;
    logic [NW-1:0]        div_den;
    logic [QW-1:0]        div_q;
    logic signed [PW-1:0] q_s;
    logic signed [SB-1:0] od_y;
    logic signed [SB-1:0] di_y;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        rev_len_eff = 32'(r_rev_len);
        if (rev_len_eff == 32'd0) begin
            rev_len_eff = 32'd1;
        end else if (rev_len_eff > 32'(REVERB_DEPTH)) begin
            rev_len_eff = 32'(REVERB_DEPTH);
        end
        wah_len_eff = 32'(r_wah_len);
        if (wah_len_eff == 32'd0) begin
            wah_len_eff = 32'd1;
        end else if (wah_len_eff > 32'(WAH_DEPTH)) begin
            wah_len_eff = 32'(WAH_DEPTH);
        end
    end

    assign trem_next = {1'b0, r_trem_count} + 23'd1;
    assign x_mag     = r_x[SB-1] ? -{r_x[SB-1], r_x} : {r_x[SB-1], r_x};

    // shared multiplier operand select
    always_comb begin
        mul_a = {r_x[SB-1], r_x};
        mul_b = '0;
        unique case (r_state)
            S_OD_A:  begin
                mul_a = x_mag;
                mul_b = 18'(32'd16384 + 32'(r_drive));
            end
            S_OD_B:  begin
                mul_a = x_mag;
                mul_b = $signed({2'b0, r_drive});
            end
            S_DI_M:  mul_b = $signed({3'b0, r_dist_gain});
            S_RV_M:  begin
                mul_a = {r_rev_rd[SB-1], r_rev_rd};
                mul_b = $signed({3'b0, r_rev_decay});
            end
            S_TR_M:  mul_b = $signed({3'b0, r_trem_gain});
            S_WH_M1: begin
                mul_a = {r_band[SB-1], r_band};
                mul_b = 18'(TENTH_Q15);
            end
            S_WH_M2: begin
                mul_a = {r_high[SB-1], r_high};
                mul_b = $signed({2'b0, r_coef});
            end
            S_WH_M3: begin
                mul_a = {r_band[SB-1], r_band};
                mul_b = $signed({2'b0, r_coef});
            end
            default: mul_b = '0;
        endcase
        ma_e = $signed({{(PW-SB-1){mul_a[SB]}}, mul_a});
        mb_e = $signed({{(PW-18){mul_b[17]}}, mul_b});
    end

    assign div_start = (r_state == S_OD_C);
    assign div_den   = NW'(64'd1 << (F + 14)) + NW'(r_prod);

    gfx_div #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (r_a),
        .i_den  (div_den),
        .o_done (div_done),
        .o_quot (div_q)
    );

    always_comb begin
        q_s  = $signed({{(PW-QW){1'b0}}, div_q});
        od_y = r_x[SB-1] ? sat(-q_s) : sat(q_s);
        if (r_prod > CLIP_P) begin
            di_y = SB'(CLIP_LVL);
        end else if (r_prod < NCLIP_P) begin
            di_y = SB'(-CLIP_LVL);
        end else begin
            di_y = sat(trunc_sh(r_prod, 12));
        end
        rev_v = sat(trunc_sh(r_prod, 15) + ext(r_x));
    end

    // delay line and wah coefficient memory port control
    always_comb begin
        rev_we = 1'b0;
        rev_wa = r_rev_pos;
        rev_wd = rev_v;
        if (r_state == S_CLR) begin
            rev_we = 1'b1;
            rev_wa = r_clr_cnt;
            rev_wd = '0;
        end else if (r_state == S_RV_W) begin
            rev_we = 1'b1;
        end
        rev_re = accept && (i_op == OP_SAMPLE) && (r_fx_mode == MODE_REVERB);
        wah_re = accept && (i_op == OP_SAMPLE) && (r_fx_mode == MODE_WAH);
        wah_we = accept && (i_op == OP_COEFF) && (32'(i_coeff_index) < 32'(WAH_DEPTH));
        wah_wa = WA'(32'(i_coeff_index));
    end

    always_ff @(posedge i_clk) begin
        if (rev_we) begin
            rev_mem[rev_wa] <= rev_wd;
        end
        if (rev_re) begin
            r_rev_rd <= rev_mem[r_rev_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wah_we) begin
            wah_mem[wah_wa] <= i_coeff_value;
        end
        if (wah_re) begin
            r_coef <= wah_mem[r_wah_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(ma_e * mb_e);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx_mode     <= MODE_BYPASS;
            r_drive       <= 16'd32768;
            r_dist_gain   <= 15'd16384;
            r_rev_decay   <= 15'd16384;
            r_rev_len     <= 15'd8820;
            r_trem_period <= 22'd8820;
            r_trem_gain   <= 15'd0;
            r_wah_len     <= 18'd66150;
            r_state       <= S_CLR;
            r_clr_cnt     <= '0;
            r_rev_pos     <= '0;
            r_trem_count  <= '0;
            r_trem_on     <= 1'b1;
            r_wah_pos     <= '0;
            r_band        <= '0;
            r_low         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FX_MODE: begin
                        r_fx_mode <= i_cfg_data[2:0];
                        if (i_cfg_data[2:0] == MODE_REVERB) begin
                            r_rev_pos <= '0;
                        end else if (i_cfg_data[2:0] == MODE_TREMOLO) begin
                            r_trem_count <= '0;
                        end else if (i_cfg_data[2:0] == MODE_WAH) begin
                            r_wah_pos <= '0;
                        end
                    end
                    CFG_DRIVE_COEFF:   r_drive       <= i_cfg_data[15:0];
                    CFG_DIST_GAIN:     r_dist_gain   <= i_cfg_data[14:0];
                    CFG_REVERB_DECAY:  r_rev_decay   <= i_cfg_data[14:0];
                    CFG_REVERB_LENGTH: r_rev_len     <= i_cfg_data[14:0];
                    CFG_TREM_PERIOD:   r_trem_period <= i_cfg_data[21:0];
                    CFG_TREM_OFF_GAIN: r_trem_gain   <= i_cfg_data[14:0];
                    CFG_WAH_LENGTH:    r_wah_len     <= i_cfg_data[17:0];
                    default:           r_wah_len     <= r_wah_len;
                endcase
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLR: begin
                    r_clr_cnt <= r_clr_cnt + RA'(1);
                    if (32'(r_clr_cnt) == 32'(REVERB_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept && (i_op == OP_SAMPLE)) begin
                        r_x <= i_sample_in;
                        case (r_fx_mode)
                            MODE_OVERDRIVE: r_state <= S_OD_A;
                            MODE_DIST:      r_state <= S_DI_M;
                            MODE_REVERB:    r_state <= S_RV_M;
                            MODE_TREMOLO: begin
                                if (trem_next >= {1'b0, r_trem_period}) begin
                                    r_trem_on    <= !r_trem_on;
                                    r_trem_count <= '0;
                                end else begin
                                    r_trem_count <= trem_next[21:0];
                                end
                                r_state <= S_TR_M;
                            end
                            MODE_WAH: begin
                                if (r_wah_pos == '0) begin
                                    r_band  <= '0;
                                    r_low   <= '0;
                                    r_y     <= '0;
                                    r_state <= S_FIN;
                                end else begin
                                    r_state <= S_WH_M1;
                                end
                                if (32'(r_wah_pos) + 32'd1 >= wah_len_eff) begin
                                    r_wah_pos <= '0;
                                end else begin
                                    r_wah_pos <= r_wah_pos + WA'(1);
                                end
                            end
                            default: begin
                                r_y     <= i_sample_in;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_OD_A: r_state <= S_OD_B;
                S_OD_B: begin
                    r_a     <= NW'(r_prod);
                    r_state <= S_OD_C;
                end
                S_OD_C: r_state <= S_OD_W;
                S_OD_W: begin
                    if (div_done) begin
                        r_y     <= od_y;
                        r_state <= S_FIN;
                    end
                end
                S_DI_M: r_state <= S_DI_R;
                S_DI_R: begin
                    r_y     <= di_y;
                    r_state <= S_FIN;
                end
                S_RV_M: r_state <= S_RV_W;
                S_RV_W: begin
                    r_y <= rev_v;
                    if (32'(r_rev_pos) + 32'd1 >= rev_len_eff) begin
                        r_rev_pos <= '0;
                    end else begin
                        r_rev_pos <= r_rev_pos + RA'(1);
                    end
                    r_state <= S_FIN;
                end
                S_TR_M: r_state <= S_TR_R;
                S_TR_R: begin
                    r_y     <= r_trem_on ? r_x : sat(trunc_sh(r_prod, 15));
                    r_state <= S_FIN;
                end
                S_WH_M1: r_state <= S_WH_H;
                S_WH_H: begin
                    r_high  <= sat(ext(r_x) - ext(r_low) - trunc_sh(r_prod, 15));
                    r_state <= S_WH_M2;
                end
                S_WH_M2: r_state <= S_WH_B;
                S_WH_B: begin
                    r_band  <= sat(trunc_sh(r_prod, 15) + ext(r_band));
                    r_state <= S_WH_M3;
                end
                S_WH_M3: r_state <= S_WH_L;
                S_WH_L: begin
                    r_low   <= sat(trunc_sh(r_prod, 15) + ext(r_low));
                    r_y     <= r_band;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // hand the result over once the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out       <= r_y;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

endmodule
